// File: rtl/blinking_status_led_bar_unit_macros.svh
// Assertion helpers used by the checker file of the status LED bar.
`ifndef BLINKING_STATUS_LED_BAR_UNIT_MACROS_SVH
`define BLINKING_STATUS_LED_BAR_UNIT_MACROS_SVH

// Checked on every rising edge of clk once reset has been released.
`define BSL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define BSL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bsl_pkg.sv
package bsl_pkg;

    localparam int LED_IDX_W = 5;
    localparam int POS_W = 11;
    localparam int PALETTE_N = 8;
    localparam int MASK_W = 8;
    localparam logic [POS_W:0] POS_SAT = 12'd1024;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_SET    = 3'd1,
        ACT_HEART  = 3'd2,
        ACT_COLOUR = 3'd3,
        ACT_QUERY  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        CFG_FIRST_PIXEL = 3'd0,
        CFG_BLOCK_WIDTH = 3'd1,
        CFG_BLOCK_GAP   = 3'd2,
        CFG_LINE_WIDTH  = 3'd3,
        CFG_MIN_PERIOD  = 3'd4
    } cfg_idx_t;

    localparam logic [23:0] PALETTE888 [PALETTE_N] = '{
        24'hFF2A24, 24'h2A657F, 24'h5EC874, 24'hFF552A,
        24'hF1CA0E, 24'h7F7F7F, 24'hFF2A7F, 24'h2AAA55
    };

    // Request fields seen by every cell while an item walks the chain.
    typedef struct packed {
        action_t     action;
        logic [2:0]  led;
        logic        on_flag;
        logic [31:0] on_ms;
        logic [31:0] off_ms;
        logic [15:0] colour;
        logic [31:0] now_ms;
        logic [9:0]  pixel_x;
    } req_t;

    typedef struct packed {
        logic [9:0]  block_width;
        logic [9:0]  block_gap;
        logic [9:0]  line_width;
        logic [15:0] min_period;
    } cfg_t;

    // Handed from one cell to the next, one hop per cycle.
    typedef struct packed {
        logic             go;
        logic             changed;
        logic [15:0]      pix;
        logic [POS_W-1:0] pos;
    } link_t;

    function automatic logic [15:0] to565(input logic [23:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

    function automatic logic [31:0] at_least(input logic [31:0] p, input logic [15:0] m);
        logic [31:0] m32;
        m32 = 32'(m);
        return (p < m32) ? m32 : p;
    endfunction

endpackage

// File: rtl/bsl_cell.sv
module bsl_cell
    import bsl_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  req,
    input  cfg_t  cfg,
    input  link_t link_in,
    output link_t link_out,
    output logic  lit
);

    localparam logic [LED_IDX_W-1:0] MY_IDX = LED_IDX_W'(IDX);
    localparam int PAL_SEL = IDX % PALETTE_N;
    localparam logic [15:0] RESET_COLOUR = to565(PALETTE888[PAL_SEL]);

    logic        lit_reg, lit_next;
    logic        blink_reg, blink_next;
    logic [31:0] on_per_reg, on_per_next;
    logic [31:0] off_per_reg, off_per_next;
    logic [31:0] last_reg, last_next;
    logic [15:0] colour_reg, colour_next;
    logic        go_reg;
    logic        chg_reg, chg_next;
    logic [15:0] pix_reg, pix_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic        selected;
    logic        mine;
    logic [31:0] period;
    logic [31:0] elapsed;
    logic [POS_W:0] pos_sum;
    logic [POS_W:0] blk_end;
    logic [POS_W:0] blk_stop;
    logic [POS_W:0] line_w;
    logic [POS_W:0] x_ext;
    logic [POS_W:0] pos_ext;
    logic        hit;

    assign selected = (LED_IDX_W'(req.led) == MY_IDX);
    assign period   = at_least(lit_reg ? on_per_reg : off_per_reg, cfg.min_period);
    assign elapsed  = req.now_ms - last_reg;

    assign line_w   = (POS_W + 1)'(cfg.line_width);
    assign x_ext    = (POS_W + 1)'(req.pixel_x);
    assign pos_ext  = (POS_W + 1)'(link_in.pos);
    assign blk_end  = pos_ext + (POS_W + 1)'(cfg.block_width);
    assign blk_stop = (blk_end > line_w) ? line_w : blk_end;
    assign hit      = lit_reg && (pos_ext < line_w) && (x_ext >= pos_ext) && (x_ext < blk_stop);

    // The next block starts one width and one gap further on; past the line
    // nothing is drawn, so the position saturates at 1024, beyond any line width.
    assign pos_sum = pos_ext + (POS_W + 1)'(cfg.block_width) + (POS_W + 1)'(cfg.block_gap);
    assign pos_next = (pos_sum >= POS_SAT) ? POS_SAT[POS_W-1:0] : pos_sum[POS_W-1:0];

    always_comb
    begin
        lit_next     = lit_reg;
        blink_next   = blink_reg;
        on_per_next  = on_per_reg;
        off_per_next = off_per_reg;
        last_next    = last_reg;
        colour_next  = colour_reg;
        mine         = 1'b0;
        pix_next     = link_in.pix;
        if (link_in.go)
        begin
            case (req.action)
                ACT_TICK:
                begin
                    if (blink_reg && (elapsed >= period))
                    begin
                        lit_next  = !lit_reg;
                        last_next = req.now_ms;
                        mine      = 1'b1;
                    end
                end
                ACT_SET:
                begin
                    if (selected)
                    begin
                        blink_next = 1'b0;
                        lit_next   = req.on_flag;
                        mine       = (lit_reg != req.on_flag);
                    end
                end
                ACT_HEART:
                begin
                    if (selected)
                    begin
                        on_per_next  = at_least(req.on_ms, cfg.min_period);
                        off_per_next = at_least(req.off_ms, cfg.min_period);
                        blink_next   = 1'b1;
                        lit_next     = 1'b1;
                        last_next    = req.now_ms;
                        mine         = !lit_reg;
                    end
                end
                ACT_COLOUR:
                begin
                    if (selected && (req.colour != colour_reg))
                    begin
                        colour_next = req.colour;
                        mine        = 1'b1;
                    end
                end
                ACT_QUERY:
                begin
                    if (hit)
                    begin
                        pix_next = colour_reg;
                    end
                end
                default:
                begin
                    mine = 1'b0;
                end
            endcase
        end
        chg_next = link_in.changed | mine;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_reg     <= 1'b0;
            blink_reg   <= 1'b0;
            on_per_reg  <= '0;
            off_per_reg <= '0;
            last_reg    <= '0;
            colour_reg  <= RESET_COLOUR;
            go_reg      <= 1'b0;
        end
        else
        begin
            lit_reg     <= lit_next;
            blink_reg   <= blink_next;
            on_per_reg  <= on_per_next;
            off_per_reg <= off_per_next;
            last_reg    <= last_next;
            colour_reg  <= colour_next;
            go_reg      <= link_in.go;
        end
    end

    always_ff @(posedge clk)
    begin
        chg_reg <= chg_next;
        pix_reg <= pix_next;
        pos_reg <= pos_next;
    end

    assign link_out.go      = go_reg;
    assign link_out.changed = chg_reg;
    assign link_out.pix     = pix_reg;
    assign link_out.pos     = pos_reg;
    assign lit              = lit_reg;

endmodule

// File: rtl/blinking_status_led_bar_unit.sv
// Channel   Signals                                 Request moves when
// input     in_valid, in_stall, action .. pixel_x   in_valid && !in_stall
// output    out_valid, out_stall, pixel565 .. toggled out_valid && !out_stall
// config    cfg_we, cfg_index, cfg_data             cfg_we
//
// A request walks the row of LED cells one cell per cycle; its result then waits
// in a pending register and moves to the output register when the output is free.
// in_stall is high from acceptance until the result moves into the output
// register; a result waiting on out_stall does not block the next request.
// Reset is asynchronous and restores the default registers and palette.
module blinking_status_led_bar_unit
    import bsl_pkg::*;
#(
    parameter int NUM_LEDS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [2:0]  led,
    input  logic        on_flag,
    input  logic [31:0] on_ms,
    input  logic [31:0] off_ms,
    input  logic [23:0] colour888,
    input  logic [31:0] now_ms,
    input  logic [9:0]  pixel_x,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] pixel565,
    output logic [7:0]  lit_mask,
    output logic        toggled,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [9:0]  first_pixel_reg;
    cfg_t        cfg_reg;
    req_t        req_reg;
    logic        start_reg;
    logic        busy_reg;
    logic        pend_valid_reg;
    logic [15:0] pend_pix_reg;
    logic [MASK_W-1:0] pend_mask_reg;
    logic        pend_chg_reg;
    logic        out_valid_reg;
    logic [15:0] out_pix_reg;
    logic [MASK_W-1:0] out_mask_reg;
    logic        out_chg_reg;

    logic        in_take;
    logic        out_free;
    logic        move_out;
    link_t       link [NUM_LEDS + 1];
    logic [NUM_LEDS-1:0] lit_vec;
    logic [MASK_W-1:0]   mask_now;

    assign in_take  = in_valid && !busy_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign move_out = pend_valid_reg && out_free;

    assign link[0].go      = start_reg;
    assign link[0].changed = 1'b0;
    assign link[0].pix     = '0;
    assign link[0].pos     = POS_W'(first_pixel_reg);

    for (genvar i = 0; i < NUM_LEDS; i++)
    begin : g_cell
        bsl_cell #(
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .req      (req_reg),
            .cfg      (cfg_reg),
            .link_in  (link[i]),
            .link_out (link[i + 1]),
            .lit      (lit_vec[i])
        );
    end

    for (genvar j = 0; j < MASK_W; j++)
    begin : g_mask
        if (j < NUM_LEDS)
        begin : g_led
            assign mask_now[j] = lit_vec[j];
        end
        else
        begin : g_none
            assign mask_now[j] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pixel_reg     <= 10'd128;
            cfg_reg.block_width <= 10'd32;
            cfg_reg.block_gap   <= 10'd40;
            cfg_reg.line_width  <= 10'd800;
            cfg_reg.min_period  <= 16'd200;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FIRST_PIXEL: first_pixel_reg     <= cfg_data[9:0];
                CFG_BLOCK_WIDTH: cfg_reg.block_width <= cfg_data[9:0];
                CFG_BLOCK_GAP:   cfg_reg.block_gap   <= cfg_data[9:0];
                CFG_LINE_WIDTH:  cfg_reg.line_width  <= cfg_data[9:0];
                CFG_MIN_PERIOD:  cfg_reg.min_period  <= cfg_data;
                default:         first_pixel_reg     <= first_pixel_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg      <= 1'b0;
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= in_take;
            if (in_take)
            begin
                busy_reg <= 1'b1;
            end
            else if (move_out)
            begin
                busy_reg <= 1'b0;
            end
            if (link[NUM_LEDS].go)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (move_out)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (move_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg.action  <= action_t'(action);
            req_reg.led     <= led;
            req_reg.on_flag <= on_flag;
            req_reg.on_ms   <= on_ms;
            req_reg.off_ms  <= off_ms;
            req_reg.colour  <= to565(colour888);
            req_reg.now_ms  <= now_ms;
            req_reg.pixel_x <= pixel_x;
        end
        // The last cell has updated its LED on the edge that raised its go,
        // so every lit flag is final here.
        if (link[NUM_LEDS].go)
        begin
            pend_pix_reg  <= link[NUM_LEDS].pix;
            pend_chg_reg  <= link[NUM_LEDS].changed;
            pend_mask_reg <= mask_now;
        end
        if (move_out)
        begin
            out_pix_reg  <= pend_pix_reg;
            out_mask_reg <= pend_mask_reg;
            out_chg_reg  <= pend_chg_reg;
        end
    end

    assign in_stall  = busy_reg;
    assign out_valid = out_valid_reg;
    assign pixel565  = out_pix_reg;
    assign lit_mask  = out_mask_reg;
    assign toggled   = out_chg_reg;

endmodule

// File: rtl/bsl_checker.sv
`include "blinking_status_led_bar_unit_macros.svh"

module bsl_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] pixel565,
    input logic [7:0]  lit_mask,
    input logic        toggled
);

    logic in_acc;

    assign in_acc = in_valid && !in_stall;

    // A waiting result keeps its contents until it is taken.
    `BSL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(pixel565) && $stable(lit_mask) && $stable(toggled), "stalled result changed")

    // The block works on one request at a time.
    `BSL_ASSERT(a_busy_after_accept, in_acc |=> in_stall, "request accepted while busy")

    // A result never appears in the cycle after its request was accepted.
    `BSL_ASSERT(a_no_instant_result, in_acc |=> !$rose(out_valid), "result came too early")

    // A new result is shown exactly when the block frees its input.
    `BSL_ASSERT(a_free_on_result, $rose(out_valid) |-> !in_stall, "input still stalled at result")

endmodule

bind blinking_status_led_bar_unit bsl_checker u_bsl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel565  (pixel565),
    .lit_mask  (lit_mask),
    .toggled   (toggled)
);

// File: tb/blinking_status_led_bar_unit_test.sv
`timescale 1ns / 1ps

module blinking_status_led_bar_unit_test;
    import bsl_pkg::*;

    localparam int LAMP_COUNT = 8;
    localparam int SETTLE_CYCLES = LAMP_COUNT + 4;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_PRINTED = 40;
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam logic [2:0] CFG_SPARE = 3'd7;

    typedef struct {
        logic [2:0]  action;
        logic [2:0]  led;
        logic        on_flag;
        logic [31:0] on_ms;
        logic [31:0] off_ms;
        logic [23:0] colour888;
        logic [31:0] now_ms;
        logic [9:0]  pixel_x;
    } led_request_t;

    typedef struct {
        logic [15:0] pixel565;
        logic [7:0]  lit_mask;
        logic        toggled;
    } bar_status_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [2:0]  led;
    logic        on_flag;
    logic [31:0] on_ms;
    logic [31:0] off_ms;
    logic [23:0] colour888;
    logic [31:0] now_ms;
    logic [9:0]  pixel_x;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] pixel565;
    logic [7:0]  lit_mask;
    logic        toggled;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // Predicted state of the LED row and its geometry registers.
    logic [LAMP_COUNT-1:0] lamp_on;
    logic [LAMP_COUNT-1:0] lamp_blink;
    logic [31:0] on_len [LAMP_COUNT];
    logic [31:0] off_len [LAMP_COUNT];
    logic [31:0] toggled_at [LAMP_COUNT];
    logic [15:0] lamp_rgb565 [LAMP_COUNT];
    logic [9:0]  x_origin;
    logic [9:0]  blk_w;
    logic [9:0]  blk_gap;
    logic [9:0]  vis_w;
    logic [15:0] shortest_ms;

    bar_status_t expected_status [$];
    bar_status_t oldest;
    logic [31:0] wall_ms = '0;
    bit tx_paced = 1'b1;
    bit rx_paced = 1'b1;
    int rx_hold_cycles = 0;
    int long_holds = 0;
    int mismatch_count = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int settings_loaded = 0;
    int quiet_cycles = 0;

    blinking_status_led_bar_unit #(.NUM_LEDS(LAMP_COUNT)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .led(led),
        .on_flag(on_flag),
        .on_ms(on_ms),
        .off_ms(off_ms),
        .colour888(colour888),
        .now_ms(now_ms),
        .pixel_x(pixel_x),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pixel565(pixel565),
        .lit_mask(lit_mask),
        .toggled(toggled),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] pack565(input logic [23:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

    function automatic logic [31:0] clamp_period(input logic [31:0] p);
        logic [31:0] floor_ms;
        floor_ms = {16'h0000, shortest_ms};
        return (p < floor_ms) ? floor_ms : p;
    endfunction

    task automatic reset_model();
        logic [23:0] palette [LAMP_COUNT];
        palette = '{24'hFF2A24, 24'h2A657F, 24'h5EC874, 24'hFF552A,
                    24'hF1CA0E, 24'h7F7F7F, 24'hFF2A7F, 24'h2AAA55};
        x_origin = 10'd128;
        blk_w = 10'd32;
        blk_gap = 10'd40;
        vis_w = 10'd800;
        shortest_ms = 16'd200;
        lamp_on = '0;
        lamp_blink = '0;
        for (int i = 0; i < LAMP_COUNT; i++)
        begin
            on_len[i] = '0;
            off_len[i] = '0;
            toggled_at[i] = '0;
            lamp_rgb565[i] = pack565(palette[i]);
        end
    endtask

    // Later blocks are drawn over earlier ones, so the highest lit index wins.
    function automatic logic [15:0] colour_under(input logic [9:0] x);
        logic [15:0] c;
        int x0;
        int x1;
        c = '0;
        for (int i = 0; i < LAMP_COUNT; i++)
        begin
            x0 = int'(x_origin) + i * (int'(blk_w) + int'(blk_gap));
            x1 = x0 + int'(blk_w);
            if (x1 > int'(vis_w))
                x1 = int'(vis_w);
            if (lamp_on[i] && x0 < int'(vis_w) && int'(x) >= x0 && int'(x) < x1)
                c = lamp_rgb565[i];
        end
        return c;
    endfunction

    function automatic bar_status_t advance_led_bar(input led_request_t r);
        bar_status_t s;
        logic [31:0] period;
        logic [15:0] rgb;
        s.pixel565 = '0;
        s.toggled = 1'b0;
        case (r.action)
            ACT_TICK:
            begin
                for (int i = 0; i < LAMP_COUNT; i++)
                begin
                    period = clamp_period(lamp_on[i] ? on_len[i] : off_len[i]);
                    if (lamp_blink[i] && (r.now_ms - toggled_at[i]) >= period)
                    begin
                        lamp_on[i] = ~lamp_on[i];
                        toggled_at[i] = r.now_ms;
                        s.toggled = 1'b1;
                    end
                end
            end
            ACT_SET:
            begin
                lamp_blink[r.led] = 1'b0;
                s.toggled = (lamp_on[r.led] != r.on_flag);
                lamp_on[r.led] = r.on_flag;
            end
            ACT_HEART:
            begin
                on_len[r.led] = clamp_period(r.on_ms);
                off_len[r.led] = clamp_period(r.off_ms);
                lamp_blink[r.led] = 1'b1;
                s.toggled = ~lamp_on[r.led];
                lamp_on[r.led] = 1'b1;
                toggled_at[r.led] = r.now_ms;
            end
            ACT_COLOUR:
            begin
                rgb = pack565(r.colour888);
                s.toggled = (rgb != lamp_rgb565[r.led]);
                lamp_rgb565[r.led] = rgb;
            end
            ACT_QUERY:
                s.pixel565 = colour_under(r.pixel_x);
            default: ;
        endcase
        s.lit_mask = lamp_on[7:0];
        return s;
    endfunction

    function automatic led_request_t random_request();
        led_request_t r;
        r.action = 3'($urandom);
        r.led = 3'($urandom);
        r.on_flag = 1'($urandom);
        r.on_ms = $urandom;
        r.off_ms = $urandom;
        r.colour888 = 24'($urandom);
        r.now_ms = $urandom;
        r.pixel_x = 10'($urandom);
        return r;
    endfunction

    function automatic logic [31:0] pick_period(input int span);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return $urandom_range(0, span);
        else if (pick < 7)
            return $urandom_range(0, 2 * int'(shortest_ms) + 1);
        else if (pick < 9)
            return $urandom;
        else
            return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // in_valid is left high after a request is taken; the next request either
    // replaces the payload in the same step or lowers it for its gap.
    task automatic offer_request(input led_request_t r);
        int gap;
        gap = tx_paced ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action <= r.action;
        led <= r.led;
        on_flag <= r.on_flag;
        on_ms <= r.on_ms;
        off_ms <= r.off_ms;
        colour888 <= r.colour888;
        now_ms <= r.now_ms;
        pixel_x <= r.pixel_x;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        expected_status.push_back(advance_led_bar(r));
        requests_sent++;
    endtask

    task automatic drain_requests();
        in_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        case (idx)
            CFG_FIRST_PIXEL: x_origin = d[9:0];
            CFG_BLOCK_WIDTH: blk_w = d[9:0];
            CFG_BLOCK_GAP:   blk_gap = d[9:0];
            CFG_LINE_WIDTH:  vis_w = d[9:0];
            CFG_MIN_PERIOD:  shortest_ms = d;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [15:0] first, input logic [15:0] width,
                                 input logic [15:0] gap, input logic [15:0] line,
                                 input logic [15:0] minp);
        drain_requests();
        write_register(CFG_FIRST_PIXEL, first);
        write_register(CFG_BLOCK_WIDTH, width);
        write_register(CFG_BLOCK_GAP, gap);
        write_register(CFG_LINE_WIDTH, line);
        write_register(CFG_MIN_PERIOD, minp);
        write_register(CFG_SPARE, 16'($urandom));
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic random_burst(input int count);
        led_request_t r;
        logic [15:0] rgb;
        int pick;
        int span;
        int xs;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                tx_paced = ($urandom_range(0, 3) != 0);
                rx_paced = ($urandom_range(0, 3) != 0);
            end
            span = (int'(shortest_ms) > 300) ? int'(shortest_ms) : 300;
            r = random_request();
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                r.action = ACT_TICK;
                if ($urandom_range(0, 24) == 0)
                    wall_ms = $urandom;
                else
                    wall_ms = wall_ms + $urandom_range(0, span);
                r.now_ms = wall_ms;
            end
            else if (pick < 47)
                r.action = ACT_SET;
            else if (pick < 62)
            begin
                r.action = ACT_HEART;
                r.on_ms = pick_period(span);
                r.off_ms = pick_period(span);
                if ($urandom_range(0, 3) != 0)
                    r.now_ms = wall_ms;
            end
            else if (pick < 72)
            begin
                r.action = ACT_COLOUR;
                // Sometimes resend the current colour with new low bits: no change.
                if ($urandom_range(0, 4) == 0)
                begin
                    rgb = lamp_rgb565[r.led];
                    r.colour888 = {rgb[15:11], r.colour888[18:16], rgb[10:5],
                                   r.colour888[9:8], rgb[4:0], r.colour888[2:0]};
                end
            end
            else if (pick < 95)
            begin
                r.action = ACT_QUERY;
                xs = int'(x_origin) + int'($urandom_range(0, LAMP_COUNT - 1))
                     * (int'(blk_w) + int'(blk_gap))
                     + int'($urandom_range(0, int'(blk_w) + 1)) - 1;
                if ($urandom_range(0, 3) != 0 && xs >= 0 && xs < 1024)
                    r.pixel_x = 10'(xs);
            end
            else
                r.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
            offer_request(r);
        end
    endtask

    task automatic test_set_leds();
        led_request_t r;
        r = random_request();
        r.action = ACT_TICK;
        r.now_ms = '0;
        offer_request(r);
        for (int i = 0; i < LAMP_COUNT; i++)
        begin
            r = random_request();
            r.action = ACT_SET;
            r.led = 3'(i);
            r.on_flag = 1'b1;
            offer_request(r);
        end
        // Switching the same LED off twice: only the first one is a change.
        repeat (2)
        begin
            r = random_request();
            r.action = ACT_SET;
            r.led = 3'd3;
            r.on_flag = 1'b0;
            offer_request(r);
        end
    endtask

    task automatic test_pixel_query();
        led_request_t r;
        logic [9:0] probe [6] = '{10'd0, 10'd128, 10'd159, 10'd160, 10'd632, 10'd1023};
        foreach (probe[i])
        begin
            r = random_request();
            r.action = ACT_QUERY;
            r.pixel_x = probe[i];
            offer_request(r);
        end
    endtask

    task automatic test_colour_update();
        led_request_t r;
        logic [23:0] shade [3] = '{24'hFFFFFF, 24'h000000, 24'h000000};
        foreach (shade[i])
        begin
            r = random_request();
            r.action = ACT_COLOUR;
            r.led = (i == 0) ? 3'd7 : 3'd0;
            r.colour888 = shade[i];
            offer_request(r);
        end
    endtask

    task automatic test_heartbeat_wrap();
        led_request_t r;
        // Zero on period is raised to the minimum; the tick crosses the 32-bit wrap.
        r = random_request();
        r.action = ACT_HEART;
        r.led = 3'd1;
        r.on_ms = 32'h0000_0000;
        r.off_ms = 32'hFFFF_FFFF;
        r.now_ms = 32'hFFFF_FF00;
        offer_request(r);
        r = random_request();
        r.action = ACT_TICK;
        r.now_ms = 32'h0000_0010;
        offer_request(r);
        r = random_request();
        r.action = ACT_TICK;
        r.now_ms = 32'h0000_0020;
        offer_request(r);
    endtask

    task automatic test_unused_actions();
        led_request_t r;
        r = random_request();
        r.action = ACT_SPARE_LO;
        offer_request(r);
        r = random_request();
        r.action = ACT_SPARE_HI;
        offer_request(r);
    endtask

    task automatic test_zero_block_width();
        led_request_t r;
        load_settings(16'd128, 16'd0, 16'd40, 16'd800, 16'd200);
        r = random_request();
        r.action = ACT_QUERY;
        r.pixel_x = 10'd128;
        offer_request(r);
    endtask

    task automatic test_back_pressure();
        rx_hold_cycles = LONG_HOLD_CYCLES;
        tx_paced = 1'b0;
        random_burst(30);
        drain_requests();
    endtask

    task automatic test_random_settings();
        wall_ms = 32'hFFFF_F000;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: load_settings(16'd128, 16'd32, 16'd40, 16'd800, 16'd200);
                1: load_settings(16'd0, 16'd1023, 16'd0, 16'd1023, 16'd0);
                2: load_settings(16'd1023, 16'd1, 16'd1023, 16'd1, 16'hFFFF);
                3: load_settings(16'd0, 16'd0, 16'd1023, 16'd1023, 16'd1);
                default:
                    // Bits above a 10-bit register are don't-care and get junk here.
                    load_settings({6'($urandom), 10'($urandom_range(0, 400))},
                                  {6'($urandom), 10'($urandom_range(1, 100))},
                                  {6'($urandom), 10'($urandom_range(0, 100))},
                                  {6'($urandom), 10'($urandom_range(100, 1023))},
                                  (phase == 7) ? 16'($urandom)
                                               : 16'($urandom_range(0, 3000)));
            endcase
            random_burst(160);
        end
    endtask

    task automatic finish_run();
        drain_requests();
        $display("Run covered %0d requests and %0d results over %0d register settings,",
                 requests_sent, results_checked, settings_loaded);
        $display("with heartbeat wrap, block clipping and %0d long output holds; %0d mismatches.",
                 long_holds, mismatch_count);
        if (mismatch_count == 0)
            $display("blinking_status_led_bar_unit_test OK");
        else
            $display("blinking_status_led_bar_unit_test NOT OK");
        $finish;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_TICK;
        led = '0;
        on_flag = 1'b0;
        on_ms = '0;
        off_ms = '0;
        colour888 = '0;
        now_ms = '0;
        pixel_x = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_FIRST_PIXEL;
        cfg_data = '0;
        reset_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_set_leds();
        test_pixel_query();
        test_colour_update();
        test_heartbeat_wrap();
        test_unused_actions();
        test_zero_block_width();
        test_back_pressure();
        test_random_settings();
        finish_run();
    end

    // Result side: a random wait before each result while rx_paced is set, plus one long hold on request.
    initial
    begin : result_taker
        int hold;
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
                long_holds++;
            end
            hold = rx_paced ? $urandom_range(0, 8) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (expected_status.size() == 0)
                flag_mismatch("result arrived with no request outstanding");
            else
            begin
                oldest = expected_status.pop_front();
                if (pixel565 !== oldest.pixel565)
                    flag_mismatch($sformatf("pixel565 %h, predicted %h",
                                            pixel565, oldest.pixel565));
                if (lit_mask !== oldest.lit_mask)
                    flag_mismatch($sformatf("lit_mask %b, predicted %b",
                                            lit_mask, oldest.lit_mask));
                if (toggled !== oldest.toggled)
                    flag_mismatch($sformatf("toggled %b, predicted %b",
                                            toggled, oldest.toggled));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("blinking_status_led_bar_unit_test NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
